/* design/bbc_pkg.sv */
// Package for the bracket balance checker: transaction structs, bracket kind codes,
// and the byte-to-kind decode.
// No dependencies. Used by bbc_stack and bracket_balance_checker.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam logic [15:0] POS_MAX = 16'hFFFF;

	// openers are 1..3, closers 4..6; a closer's code minus 3 is its opener
	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_OPAREN = 3'd1,
		KIND_OBRACK = 3'd2,
		KIND_OBRACE = 3'd3,
		KIND_CPAREN = 3'd4,
		KIND_CBRACK = 3'd5,
		KIND_CBRACE = 3'd6
	} kind_t;

	typedef struct packed {
		logic [7:0] character;
		logic       end_of_line;
	} char_t;

	typedef struct packed {
		logic        success;
		logic [15:0] error_position;
		logic        overflow;
	} result_t;

	typedef struct packed {
		logic  push;
		logic  pop;
		logic  clear;
		kind_t kind;
	} stack_op_t;

	function automatic kind_t kind_of(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_LPAREN: k = KIND_OPAREN;
			CH_LBRACK: k = KIND_OBRACK;
			CH_LBRACE: k = KIND_OBRACE;
			CH_RPAREN: k = KIND_CPAREN;
			CH_RBRACK: k = KIND_CBRACK;
			CH_RBRACE: k = KIND_CBRACE;
			default:   k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t opener_of(input kind_t k);
		kind_t o;
		case (k)
			KIND_CPAREN: o = KIND_OPAREN;
			KIND_CBRACK: o = KIND_OBRACK;
			KIND_CBRACE: o = KIND_OBRACE;
			default:     o = KIND_NONE;
		endcase
		return o;
	endfunction

endpackage

`default_nettype wire

/* design/bracket_balance_checker.sv */
// Top level of the bracket balance checker: line state, verdict and result register.
// Depends on bbc_pkg and bbc_stack.
`timescale 1ns / 1ps
`default_nettype none

// Checks (), [] and {} for balance, one byte of a line per cycle save while an
// end-of-line transaction is held off as below; the
// stack lives in a memory with one write and one registered read port, and the
// top entry is cached while the one below is prefetched each cycle, so
// consecutive pops run at full rate. An end-of-line transaction loads the result
// register on the next edge and clears the line state at once, so the next line
// can start in the following cycle. No clearing pass follows reset. An
// end-of-line transaction is held off only while a previous result is still
// waiting and stalled; characters keep flowing regardless.
module bracket_balance_checker #(
	parameter int unsigned STACK_DEPTH = 1024,
	parameter int unsigned LINE_LENGTH = 65535
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             char_valid,
	output logic                  char_stall,
	input  wire bbc_pkg::char_t   char_data,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output bbc_pkg::result_t      result_data
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [15:0] POS_LIMIT =
		(LINE_LENGTH > 32'd65535) ? bbc_pkg::POS_MAX : LINE_LENGTH[15:0];

	logic               accept;
	logic               is_char;
	logic               is_eol;
	bbc_pkg::kind_t     kind;
	logic               is_open;
	logic               is_close;
	logic               match;
	logic               push_req;
	logic               full;
	logic [15:0]        pos;
	logic [CW-1:0]      count;
	bbc_pkg::kind_t     top;
	bbc_pkg::stack_op_t op;

	logic [15:0]        pos_q;
	logic [15:0]        first_close_pos_q;
	logic               first_close_seen_q;
	logic [15:0]        bottom_open_pos_q;
	logic               overflow_q;
	logic               result_valid_q;
	bbc_pkg::result_t   result_q;

	assign char_stall = char_data.end_of_line & result_valid_q & result_stall;
	assign accept     = char_valid & ~char_stall;
	assign is_eol     = accept & char_data.end_of_line;
	assign is_char    = accept & ~char_data.end_of_line;

	assign kind     = bbc_pkg::kind_of(char_data.character);
	assign is_open  = (kind == bbc_pkg::KIND_OPAREN) || (kind == bbc_pkg::KIND_OBRACK)
		|| (kind == bbc_pkg::KIND_OBRACE);
	assign is_close = (kind == bbc_pkg::KIND_CPAREN) || (kind == bbc_pkg::KIND_CBRACK)
		|| (kind == bbc_pkg::KIND_CBRACE);
	// an empty stack never matches
	assign match    = is_close && (count != '0) && (top == bbc_pkg::opener_of(kind));
	assign push_req = is_open || (is_close && !match);
	assign full     = (count == CW'(STACK_DEPTH));
	assign pos      = (pos_q < POS_LIMIT) ? pos_q + 16'd1 : pos_q;

	always_comb begin
		op.push  = is_char && push_req && !full;
		op.pop   = is_char && match;
		op.clear = is_eol;
		op.kind  = kind;
	end

	bbc_stack #(
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (op),
		.count (count),
		.top   (top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q              <= '0;
			first_close_pos_q  <= '0;
			first_close_seen_q <= 1'b0;
			bottom_open_pos_q  <= '0;
			overflow_q         <= 1'b0;
		end else if (is_eol) begin
			pos_q              <= '0;
			first_close_pos_q  <= '0;
			first_close_seen_q <= 1'b0;
			bottom_open_pos_q  <= '0;
			overflow_q         <= 1'b0;
		end else if (is_char) begin
			pos_q <= pos;
			if (push_req) begin
				if (is_close && !first_close_seen_q) begin
					first_close_seen_q <= 1'b1;
					first_close_pos_q  <= pos;
				end
				if (full) begin
					overflow_q <= 1'b1;
				end else if (is_open && count == '0) begin
					bottom_open_pos_q <= pos;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (is_eol) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_eol) begin
			result_q.success  <= (count == '0) && !first_close_seen_q && !overflow_q;
			result_q.overflow <= overflow_q;
			if ((count == '0) && !first_close_seen_q && !overflow_q) begin
				result_q.error_position <= '0;
			end else if (first_close_seen_q) begin
				result_q.error_position <= first_close_pos_q;
			end else begin
				result_q.error_position <= bottom_open_pos_q;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		op.pop |-> count != '0)
		else $error("stack pop with empty stack");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_eol_result: assert property (@(posedge clk) disable iff (!arst_n)
		is_eol |=> result_valid)
		else $error("end of line gave no result");

	a_success_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.success |->
			result_data.error_position == 16'd0 && !result_data.overflow)
		else $error("success with error position or overflow");

endmodule

`default_nettype wire

/* design/bbc_stack.sv */
// Bracket stack: a single-port-write, single-port-read memory with the top entry
// cached in a register and the entry below it prefetched every cycle.
// Depends on bbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbc_stack #(
	parameter int unsigned DEPTH = 1024,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bbc_pkg::stack_op_t op,
	output logic [CW-1:0]          count,
	output bbc_pkg::kind_t         top
);

	bbc_pkg::kind_t mem [DEPTH];
	bbc_pkg::kind_t top_q;
	bbc_pkg::kind_t below_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  count_d;
	logic [CW-1:0]  rd_ptr;

	always_comb begin
		count_d = count_q;
		if (op.clear) begin
			count_d = '0;
		end else if (op.push) begin
			count_d = count_q + CW'(1);
		end else if (op.pop) begin
			count_d = count_q - CW'(1);
		end
	end

	// prefetch the entry under next cycle's top so a pop can take it at once
	assign rd_ptr = count_d - CW'(2);

	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[count_q[AW-1:0]] <= op.kind;
		end
		below_q <= mem[rd_ptr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			top_q   <= bbc_pkg::KIND_NONE;
		end else begin
			count_q <= count_d;
			if (op.push) begin
				top_q <= op.kind;
			end else if (op.pop) begin
				top_q <= below_q;
			end
		end
	end

	assign count = count_q;
	assign top   = top_q;

endmodule

`default_nettype wire
